[src/integer_to_ascii_formatter_top_assert.svh]
// Assertion macros for the integer-to-ASCII formatter
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH

// same-cycle implication
`define I2A_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2A_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/i2a_pkg.sv]
// Shared constants, types and character tables of the integer-to-ASCII formatter
`timescale 1ns / 1ps

package i2a_pkg;

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 64;
    localparam int CHAR_W   = 8;
    localparam int BIN_W    = 32;
    localparam int BCD_DIGS = 10;
    localparam int BCD_W    = 4 * BCD_DIGS;
    localparam int NIBBLES  = VALUE_W / 4;
    localparam int NDIG_W   = $clog2(NIBBLES + 1);
    localparam int STEP_W   = $clog2(BIN_W);

    localparam logic [KIND_W-1:0] KIND_SDEC = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UDEC = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HEXL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HEXU = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PTR  = 3'd4;

    localparam logic [1:0] PFX_NONE  = 2'd0;
    localparam logic [1:0] PFX_MINUS = 2'd1;
    localparam logic [1:0] PFX_HEX   = 2'd2;
    localparam logic [1:0] PFX_NIL   = 2'd3;

    typedef struct packed {
        logic               go;
        logic [1:0]         pfx;
        logic               upper;
        logic [VALUE_W-1:0] digits;
    } load_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] r;
        if (d < 4'd10) begin
            r = 8'h30 + {4'b0000, d};
        end else if (upper) begin
            r = 8'h41 + {4'b0000, d} - 8'd10;
        end else begin
            r = 8'h61 + {4'b0000, d} - 8'd10;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] pfx_char(input logic [1:0] pfx,
                                                   input logic [2:0] idx);
        logic [CHAR_W-1:0] r;
        r = 8'h00;
        case (pfx)
            PFX_MINUS: r = 8'h2D;
            PFX_HEX:   r = (idx == 3'd0) ? 8'h30 : 8'h78;
            PFX_NIL: begin
                case (idx)
                    3'd0:    r = 8'h28;
                    3'd1:    r = 8'h6E;
                    3'd2:    r = 8'h69;
                    3'd3:    r = 8'h6C;
                    default: r = 8'h29;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] pfx_last_idx(input logic [1:0] pfx);
        logic [2:0] r;
        case (pfx)
            PFX_HEX: r = 3'd1;
            PFX_NIL: r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

[src/i2a_dabble.sv]
// Bit-serial binary to BCD converter (shift and add three)
`timescale 1ns / 1ps

module i2a_dabble
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [i2a_pkg::BIN_W-1:0]  bin,
    output logic                       done,
    output logic [i2a_pkg::BCD_W-1:0]  bcd
);

    logic                         run_reg, run_next;
    logic                         done_reg, done_next;
    logic [i2a_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic [i2a_pkg::BIN_W-1:0]    bin_reg, bin_next;
    logic [i2a_pkg::BCD_W-1:0]    bcd_reg, bcd_next;
    logic [i2a_pkg::BCD_W-1:0]    adj;

    always_comb
    begin
        for (int i = 0; i < i2a_pkg::BCD_DIGS; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                         : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            bin_next = bin;
            bcd_next = '0;
        end
        else if (run_reg)
        begin
            // shift one bit into the digit chain
            bcd_next = {adj[i2a_pkg::BCD_W-2:0], bin_reg[i2a_pkg::BIN_W-1]};
            bin_next = {bin_reg[i2a_pkg::BIN_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {i2a_pkg::STEP_W{1'b1}})
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

[src/i2a_emit.sv]
// Character sequencer: strips leading zero digits, emits prefix and digits ("(nil)" alone for a null pointer)
`timescale 1ns / 1ps

module i2a_emit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  i2a_pkg::load_t              load,
    output logic                        active,
    output logic                        valid,
    output logic [i2a_pkg::CHAR_W-1:0]  character,
    output logic                        last
);

    localparam logic [1:0] E_IDLE  = 2'd0;
    localparam logic [1:0] E_STRIP = 2'd1;
    localparam logic [1:0] E_PFX   = 2'd2;
    localparam logic [1:0] E_DIG   = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [i2a_pkg::VALUE_W-1:0]    dig_reg, dig_next;
    logic [i2a_pkg::NDIG_W-1:0]     ndig_reg, ndig_next;
    logic [1:0]                     pfx_reg, pfx_next;
    logic [2:0]                     pidx_reg, pidx_next;
    logic                           upper_reg, upper_next;
    logic                           valid_reg, valid_next;
    logic [i2a_pkg::CHAR_W-1:0]     char_reg, char_next;
    logic                           last_reg, last_next;
    logic [3:0]                     top_dig;

    assign top_dig = dig_reg[i2a_pkg::VALUE_W-1 -: 4];

    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        ndig_next  = ndig_reg;
        pfx_next   = pfx_reg;
        pidx_next  = pidx_reg;
        upper_next = upper_reg;
        valid_next = 1'b0;
        char_next  = char_reg;
        last_next  = 1'b0;
        case (state_reg)
            E_IDLE:
            begin
                if (load.go)
                begin
                    dig_next   = load.digits;
                    ndig_next  = i2a_pkg::NDIG_W'(i2a_pkg::NIBBLES);
                    pfx_next   = load.pfx;
                    pidx_next  = '0;
                    upper_next = load.upper;
                    state_next = (load.pfx == i2a_pkg::PFX_NIL) ? E_PFX : E_STRIP;
                end
            end
            E_STRIP:
            begin
                if (ndig_reg > 1 && top_dig == 4'd0)
                begin
                    dig_next  = {dig_reg[i2a_pkg::VALUE_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end
                else
                begin
                    state_next = (pfx_reg == i2a_pkg::PFX_NONE) ? E_DIG : E_PFX;
                end
            end
            E_PFX:
            begin
                valid_next = 1'b1;
                char_next  = i2a_pkg::pfx_char(pfx_reg, pidx_reg);
                if (pidx_reg == i2a_pkg::pfx_last_idx(pfx_reg))
                begin
                    if (pfx_reg == i2a_pkg::PFX_NIL)
                    begin
                        last_next  = 1'b1;
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        state_next = E_DIG;
                    end
                end
                else
                begin
                    pidx_next = pidx_reg + 1'b1;
                end
            end
            E_DIG:
            begin
                valid_next = 1'b1;
                char_next  = i2a_pkg::digit_char(top_dig, upper_reg);
                last_next  = (ndig_reg == 1);
                dig_next   = {dig_reg[i2a_pkg::VALUE_W-5:0], 4'd0};
                ndig_next  = ndig_reg - 1'b1;
                if (ndig_reg == 1)
                begin
                    state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg   <= dig_next;
        ndig_reg  <= ndig_next;
        pfx_reg   <= pfx_next;
        pidx_reg  <= pidx_next;
        upper_reg <= upper_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign active    = (state_reg != E_IDLE);
    assign valid     = valid_reg;
    assign character = char_reg;
    assign last      = last_reg & valid_reg;

endmodule

[src/integer_to_ascii_formatter_top.sv]
// Top level of the printf-style integer-to-ASCII formatter
`timescale 1ns / 1ps
//
// Usage:
//   Drive kind and value with start high; the item is taken at a clock edge
//   where start is high and busy is low. The text leaves one character per
//   strobe on valid, with character and last, most significant digit first;
//   last marks the final character. Undefined kinds are taken and give nothing.
// Sequencing:
//   Decimal kinds pass through the bit-serial BCD converter, then leading-zero
//   stripping (one digit a cycle), then the text leaves one character per cycle.
//   Hex kinds skip the converter; for hex and non-null pointers each stripped
//   digit is one fewer to print. "(nil)" skips the stripping.
//   busy stays high until the last character is registered for output.
// Reset:
//   rst_n clears the control state; the block comes up idle.
// Stalls:
//   The receiver takes every strobe; there is no backpressure.
//
module integer_to_ascii_formatter_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [i2a_pkg::KIND_W-1:0]   kind,
    input  logic [i2a_pkg::VALUE_W-1:0]  value,
    output logic                         valid,
    output logic [i2a_pkg::CHAR_W-1:0]   character,
    output logic                         last
);

    localparam logic T_IDLE = 1'b0;
    localparam logic T_CONV = 1'b1;

    logic                          state_reg, state_next;
    logic                          neg_reg, neg_next;
    logic                          accept;
    logic [i2a_pkg::BIN_W-1:0]     low;
    logic                          dab_go;
    logic [i2a_pkg::BIN_W-1:0]     dab_in;
    logic                          dab_done;
    logic [i2a_pkg::BCD_W-1:0]     dab_bcd;
    i2a_pkg::load_t                load;
    logic                          emit_active;

    assign low    = value[i2a_pkg::BIN_W-1:0];
    assign busy   = (state_reg == T_CONV) || emit_active;
    assign accept = start && !busy;

    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        dab_go      = 1'b0;
        dab_in      = low;
        load.go     = 1'b0;
        load.pfx    = i2a_pkg::PFX_NONE;
        load.upper  = 1'b0;
        load.digits = {{(i2a_pkg::VALUE_W-i2a_pkg::BIN_W){1'b0}}, low};
        if (accept)
        begin
            case (kind)
                i2a_pkg::KIND_SDEC:
                begin
                    dab_go     = 1'b1;
                    dab_in     = low[i2a_pkg::BIN_W-1] ? (i2a_pkg::BIN_W'(0) - low) : low;
                    neg_next   = low[i2a_pkg::BIN_W-1];
                    state_next = T_CONV;
                end
                i2a_pkg::KIND_UDEC:
                begin
                    dab_go     = 1'b1;
                    neg_next   = 1'b0;
                    state_next = T_CONV;
                end
                i2a_pkg::KIND_HEXL, i2a_pkg::KIND_HEXU:
                begin
                    load.go    = 1'b1;
                    load.upper = (kind == i2a_pkg::KIND_HEXU);
                end
                i2a_pkg::KIND_PTR:
                begin
                    load.go     = 1'b1;
                    load.pfx    = (value == '0) ? i2a_pkg::PFX_NIL : i2a_pkg::PFX_HEX;
                    load.digits = value;
                end
                default:
                begin
                    load.go = 1'b0;
                end
            endcase
        end
        else if (state_reg == T_CONV && dab_done)
        begin
            load.go     = 1'b1;
            load.pfx    = neg_reg ? i2a_pkg::PFX_MINUS : i2a_pkg::PFX_NONE;
            load.digits = {{(i2a_pkg::VALUE_W-i2a_pkg::BCD_W){1'b0}}, dab_bcd};
            state_next  = T_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
    end

    i2a_dabble u_dabble
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (dab_go),
        .bin   (dab_in),
        .done  (dab_done),
        .bcd   (dab_bcd)
    );

    i2a_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .active    (emit_active),
        .valid     (valid),
        .character (character),
        .last      (last)
    );

endmodule

[src/i2a_checker.sv]
// Port-level assertions for the integer-to-ASCII formatter and their binding
`timescale 1ns / 1ps
`include "integer_to_ascii_formatter_top_assert.svh"

module i2a_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [i2a_pkg::KIND_W-1:0]   kind,
    input logic                         valid,
    input logic                         last
);

    logic acc;
    logic bad_kind;

    assign acc      = start && !busy;
    assign bad_kind = (kind > i2a_pkg::KIND_PTR);

    `I2A_ASSERT_NOW(a_mid_busy, clk, rst_n, valid && !last, busy, "character out while idle")
    `I2A_ASSERT_NEXT(a_last_gap, clk, rst_n, valid && last, !valid, "character right after last")
    `I2A_ASSERT_NEXT(a_acc_quiet, clk, rst_n, acc, !valid, "character right after accept")
    `I2A_ASSERT_NEXT(a_bad_kind, clk, rst_n, acc && bad_kind, !busy && !valid,
                     "undefined kind started work")

endmodule

bind integer_to_ascii_formatter_top i2a_checker u_i2a_checker (.*);

[test/integer_to_ascii_formatter_top_test.sv]
// Self-checking testbench for the integer-to-ASCII formatter
`timescale 1ns / 1ps

module integer_to_ascii_formatter_top_test;

    localparam logic [i2a_pkg::KIND_W-1:0] KIND_UNDEF_LO = i2a_pkg::KIND_PTR + 3'd1;
    localparam logic [i2a_pkg::KIND_W-1:0] KIND_UNDEF_HI = {i2a_pkg::KIND_W{1'b1}};
    localparam int               MAX_GAP       = 12;
    localparam int               DRAIN_CYCLES  = 120;
    localparam int               RANDOM_ITEMS  = 430;

    typedef struct {
        logic [i2a_pkg::KIND_W-1:0]  kind;
        logic [i2a_pkg::VALUE_W-1:0] value;
        int                          gap;
    } fmt_request_t;

    typedef struct packed {
        logic [i2a_pkg::CHAR_W-1:0] character;
        logic                       last;
    } text_char_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [i2a_pkg::KIND_W-1:0]  kind;
    logic [i2a_pkg::VALUE_W-1:0] value;
    logic                        valid;
    logic [i2a_pkg::CHAR_W-1:0]  character;
    logic                        last;

    fmt_request_t pending_requests[$];
    text_char_t   expected_text[$];
    fmt_request_t next_request;
    int           n_sent;
    int           n_taken;
    int           idle_left;
    int           error_count;

    integer_to_ascii_formatter_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .value     (value),
        .valid     (valid),
        .character (character),
        .last      (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [i2a_pkg::CHAR_W-1:0] digit_code(input logic [3:0] d,
                                                              input logic upper);
        logic [i2a_pkg::CHAR_W-1:0] code;
        if (d < 4'd10)
        begin
            code = "0" + {4'b0000, d};
        end
        else
        begin
            code = (upper ? "A" : "a") + {4'b0000, d} - 8'd10;
        end
        return code;
    endfunction

    function automatic void push_expected_text(input logic [i2a_pkg::KIND_W-1:0] k,
                                               input logic [i2a_pkg::VALUE_W-1:0] v);
        logic [i2a_pkg::CHAR_W-1:0]  text[$];
        logic [i2a_pkg::CHAR_W-1:0]  digit_text[$];
        logic [31:0]                 low;
        logic [31:0]                 neg;
        logic [i2a_pkg::VALUE_W-1:0] mag;
        logic [i2a_pkg::VALUE_W-1:0] radix;
        logic                        upper;
        logic                        has_digits;
        string                       nil_word;
        text_char_t                  entry;
        low        = v[31:0];
        neg        = 32'd0 - low;
        mag        = {32'd0, low};
        radix      = 64'd10;
        upper      = 1'b0;
        has_digits = 1'b1;
        nil_word   = "(nil)";
        case (k)
            i2a_pkg::KIND_SDEC:
            begin
                if (low[31])
                begin
                    text.push_back("-");
                    mag = {32'd0, neg};
                end
            end
            i2a_pkg::KIND_UDEC: radix = 64'd10;
            i2a_pkg::KIND_HEXL: radix = 64'd16;
            i2a_pkg::KIND_HEXU:
            begin
                radix = 64'd16;
                upper = 1'b1;
            end
            i2a_pkg::KIND_PTR:
            begin
                radix = 64'd16;
                if (v == '0)
                begin
                    has_digits = 1'b0;
                    for (int i = 0; i < nil_word.len(); i++)
                    begin
                        text.push_back(nil_word[i]);
                    end
                end
                else
                begin
                    text.push_back("0");
                    text.push_back("x");
                    mag = v;
                end
            end
            default: has_digits = 1'b0;
        endcase
        if (has_digits)
        begin
            do
            begin
                digit_text.push_front(digit_code(4'(mag % radix), upper));
                mag = mag / radix;
            end
            while (mag != '0);
            text = {text, digit_text};
        end
        for (int i = 0; i < text.size(); i++)
        begin
            entry.character = text[i];
            entry.last      = (i == text.size() - 1);
            expected_text.push_back(entry);
        end
    endfunction

    function automatic void queue_request(input logic [i2a_pkg::KIND_W-1:0] k,
                                          input logic [i2a_pkg::VALUE_W-1:0] v,
                                          input int gap);
        fmt_request_t req;
        req.kind  = k;
        req.value = v;
        req.gap   = gap;
        pending_requests.push_back(req);
    endfunction

    function automatic logic [i2a_pkg::VALUE_W-1:0] random_value();
        logic [i2a_pkg::VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, i2a_pkg::VALUE_W - 1);
            1: v = {$urandom, 32'(int'($urandom_range(0, 20)) - 10)};
            2: v = {$urandom, 1'b1, 31'd0};
            3: v = {$urandom, v[31:0] >> $urandom_range(0, 31)};
            default: v = v;
        endcase
        return v;
    endfunction

    function automatic logic [i2a_pkg::KIND_W-1:0] random_kind();
        logic [i2a_pkg::KIND_W-1:0] k;
        if ($urandom_range(0, 19) == 0)
        begin
            k = i2a_pkg::KIND_W'($urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI));
        end
        else
        begin
            k = i2a_pkg::KIND_W'($urandom_range(i2a_pkg::KIND_SDEC, i2a_pkg::KIND_PTR));
        end
        return k;
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && n_taken != n_sent)
        begin
            start <= 1'b1;
        end
        else if (idle_left > 0)
        begin
            start     <= 1'b0;
            kind      <= random_kind();
            value     <= {$urandom, $urandom};
            idle_left = idle_left - 1;
        end
        else if (pending_requests.size() != 0)
        begin
            next_request = pending_requests.pop_front();
            start        <= 1'b1;
            kind         <= next_request.kind;
            value        <= next_request.value;
            idle_left    = next_request.gap;
            n_sent       = n_sent + 1;
        end
        else
        begin
            start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            push_expected_text(kind, value);
            n_taken = n_taken + 1;
        end
        if (rst_n && valid)
        begin
            if (expected_text.size() == 0)
            begin
                if (error_count < 10)
                begin
                    $display("unexpected character 0x%02h last=%0b", character, last);
                end
                error_count = error_count + 1;
            end
            else if (expected_text[0] != {character, last})
            begin
                if (error_count < 10)
                begin
                    $display("mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                             expected_text[0].character, expected_text[0].last,
                             character, last);
                end
                error_count = error_count + 1;
                void'(expected_text.pop_front());
            end
            else
            begin
                void'(expected_text.pop_front());
            end
        end
    end

    initial
    begin
        bit burst;
        int gap;
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = '0;
        value       = '0;
        n_sent      = 0;
        n_taken     = 0;
        idle_left   = 0;
        error_count = 0;
        burst       = 1'b0;

        queue_request(i2a_pkg::KIND_SDEC, 64'h0, 0);
        queue_request(i2a_pkg::KIND_SDEC, 64'hFFFF_0000_0000_0001, 0);
        queue_request(i2a_pkg::KIND_SDEC, 64'h0000_0000_FFFF_FFFF, 3);
        queue_request(i2a_pkg::KIND_SDEC, 64'h1234_5678_7FFF_FFFF, 0);
        queue_request(i2a_pkg::KIND_SDEC, 64'hFFFF_FFFF_8000_0000, 1);
        queue_request(i2a_pkg::KIND_UDEC, 64'hFFFF_FFFF_0000_0000, 0);
        queue_request(i2a_pkg::KIND_UDEC, 64'h0000_0000_FFFF_FFFF, 0);
        queue_request(i2a_pkg::KIND_UDEC, 64'hAAAA_5555_3B9A_CA00, 5);
        queue_request(i2a_pkg::KIND_HEXL, 64'h0, 0);
        queue_request(i2a_pkg::KIND_HEXL, 64'h0000_0000_DEAD_BEEF, 0);
        queue_request(i2a_pkg::KIND_HEXL, 64'hFFFF_FFFF_FFFF_FFFF, 2);
        queue_request(i2a_pkg::KIND_HEXU, 64'h0, 0);
        queue_request(i2a_pkg::KIND_HEXU, 64'h5555_AAAA_ABCD_EF01, 0);
        queue_request(i2a_pkg::KIND_HEXU, 64'h0000_0000_0000_000F, 0);
        queue_request(i2a_pkg::KIND_PTR,  64'h0, 0);
        queue_request(i2a_pkg::KIND_PTR,  64'h1, 4);
        queue_request(i2a_pkg::KIND_PTR,  64'hFFFF_FFFF_FFFF_FFFF, 0);
        queue_request(i2a_pkg::KIND_PTR,  64'h0000_0001_0000_0000, 0);
        queue_request(i2a_pkg::KIND_PTR,  64'h8000_0000_0000_0000, 0);
        queue_request(i2a_pkg::KIND_PTR,  64'h0123_4567_89AB_CDEF, 0);
        queue_request(KIND_UNDEF_LO, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        queue_request(KIND_UNDEF_LO + 3'd1, 64'h0, 0);
        queue_request(KIND_UNDEF_HI, 64'h1234_5678_9ABC_DEF0, 0);
        queue_request(i2a_pkg::KIND_HEXL, 64'h0000_0000_0000_00A0, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                burst = !burst;
            end
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            queue_request(random_kind(), random_value(), gap);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || n_taken != n_sent || expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_text.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
